// File: rtl/zsn_pkg.sv
// ----------------------------------------------------------------------------
// zsn_pkg: shared types and constants of the frame z-score normalizer
// Transfer payloads and fixed widths of the normalized output.
// ----------------------------------------------------------------------------
package zsn_pkg;

    // fixed widths of the payload fields
    localparam int SAMPLE_W = 16;
    localparam int Z_W      = 20;
    localparam int IDX_W    = 10;
    localparam int FRAC_W   = 12;

    // quotient bits, one more than the output so saturation can be seen
    localparam int QUOT_W = Z_W + 1;

    // saturation limits of the signed Q8.12 output
    localparam logic [QUOT_W-1:0] Z_POS_LIMIT = QUOT_W'(524287);
    localparam logic [QUOT_W-1:0] Z_NEG_LIMIT = QUOT_W'(524288);
    localparam logic [Z_W-1:0]    Z_MAX       = Z_W'(524287);
    localparam logic [Z_W-1:0]    Z_MIN       = Z_W'(524288);

    // command codes
    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_READ = 1'b1;

    typedef struct packed {
        logic                       command;
        logic signed [SAMPLE_W-1:0] sample;
        logic                       end_of_frame;
    } request_t;

    typedef struct packed {
        logic signed [Z_W-1:0] normalized;
        logic [IDX_W-1:0]      sample_index;
        logic                  last_of_frame;
        logic                  valid_res;
        logic                  zero_spread;
        logic                  overflowed;
    } result_t;

endpackage

// File: rtl/zsn_stream_if.sv
// ----------------------------------------------------------------------------
// zsn_stream_if: valid/ready channel
// One transfer when valid and ready are both high at a rising clock edge.
// ----------------------------------------------------------------------------
interface zsn_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: rtl/frame_zscore_normalizer_top.sv
// ----------------------------------------------------------------------------
// frame_zscore_normalizer_top: z-score normalization of a sample frame
// Push: the squaring loop takes one multiplier step per significant bit of |sample|.
// Closing push adds the serial N*Q and S*S products (one bit per cycle each)
// and a digit-by-digit square root of the spread.
// Read: N*x multiply, then the restoring divider, one read at a time.
// Asynchronous active-low reset clears the frame state; sample store is not cleared.
// ----------------------------------------------------------------------------
module frame_zscore_normalizer_top #(
    parameter int FRAME_SIZE  = 1024,
    parameter int SAMPLE_BITS = 16
) (
    input logic          clk,
    input logic          rst_n,
    zsn_stream_if.sink   request,
    zsn_stream_if.source response
);
    import zsn_pkg::*;

    localparam int SB  = SAMPLE_BITS;
    localparam int NB  = $clog2(FRAME_SIZE + 1);
    localparam int AW  = $clog2(FRAME_SIZE);
    localparam int SW  = SB + NB;
    localparam int QW  = 2 * SB - 2 + NB;
    localparam int DW0 = NB + QW;
    localparam int DW  = DW0 + (DW0 % 2);
    localparam int RW  = DW / 2;
    localparam int PW  = DW;
    localparam int BW  = SW;
    localparam int NUMW = SB + NB + 1;
    localparam int MAGW = NUMW + FRAC_W;
    localparam int XE   = ((SB > SAMPLE_W) ? SB : SAMPLE_W) + 1;
    localparam logic signed [XE-1:0] SMAX = XE'((1 << (SB - 1)) - 1);
    localparam logic signed [XE-1:0] SMIN = XE'(-(1 << (SB - 1)));

    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_SQR   = 11'b00000000010,
        S_CLOSE = 11'b00000000100,
        S_NQ    = 11'b00000001000,
        S_SS    = 11'b00000010000,
        S_ROOT  = 11'b00000100000,
        S_RDM   = 11'b00001000000,
        S_XMUL  = 11'b00010000000,
        S_ZCALC = 11'b00100000000,
        S_DIV   = 11'b01000000000,
        S_EMIT  = 11'b10000000000
    } state_t;

    state_t                 state_reg;
    logic [NB-1:0]          count_reg;
    logic [NB-1:0]          rp_reg;
    logic signed [SW-1:0]   sum_reg;
    logic [QW-1:0]          sq_reg;
    logic [RW-1:0]          root_reg;
    logic                   closed_reg;
    logic                   ovf_reg;
    logic                   eof_reg;
    logic                   out_valid_reg;
    result_t                out_reg;
    result_t                pend_reg;
    logic [DW-1:0]          nq_reg;
    logic signed [NUMW-1:0] num_reg;
    logic                   xneg_reg;
    logic signed [SB-1:0]   rd_reg;
    logic signed [SB-1:0]   mem [FRAME_SIZE];

    logic                   push_acc;
    logic                   read_acc;
    logic                   emit_go;
    logic signed [XE-1:0]   x_ext;
    logic signed [XE-1:0]   x_sat;
    logic signed [SB-1:0]   x_cl;
    logic [SB-1:0]          x_mag;
    logic [SB-1:0]          rd_mag;
    logic [NB-1:0]          eff_count;
    logic                   full;
    logic signed [SW-1:0]   base_sum;
    logic [SW-1:0]          s_mag;
    logic                   no_data;
    logic [DW-1:0]          spread_d;
    logic signed [NUMW-1:0] nx_s;
    logic [NUMW-1:0]        num_mag;
    logic [Z_W-1:0]         z_val;
    logic [IDX_W-1:0]       cur_idx;
    logic                   cur_last;

    logic                   mul_start;
    logic [PW-1:0]          mul_a;
    logic [BW-1:0]          mul_b;
    logic                   mul_done;
    logic [PW-1:0]          mul_prod;
    logic                   root_start;
    logic                   root_done;
    logic [RW-1:0]          root_val;
    logic                   div_start;
    logic                   div_done;
    logic                   div_sat;
    logic [QUOT_W-1:0]      div_quot;

    // handshake
    assign request.ready  = (state_reg == S_IDLE);
    assign response.valid = out_valid_reg;
    assign response.payload = out_reg;
    assign push_acc = request.valid && (state_reg == S_IDLE)
                      && (request.payload.command == CMD_PUSH);
    assign read_acc = request.valid && (state_reg == S_IDLE)
                      && (request.payload.command == CMD_READ);
    assign emit_go  = (state_reg == S_EMIT) && (!out_valid_reg || response.ready);

    // sample clamp to the configured width
    assign x_ext = XE'(request.payload.sample);
    always_comb
    begin
        if (x_ext > SMAX)
        begin
            x_sat = SMAX;
        end
        else if (x_ext < SMIN)
        begin
            x_sat = SMIN;
        end
        else
        begin
            x_sat = x_ext;
        end
    end
    assign x_cl   = SB'(x_sat);
    assign x_mag  = x_cl[SB-1] ? SB'(-x_cl) : SB'(x_cl);
    assign rd_mag = rd_reg[SB-1] ? SB'(-rd_reg) : SB'(rd_reg);

    // a push after a closed frame starts from a cleared frame
    assign eff_count = closed_reg ? '0 : count_reg;
    assign full      = (eff_count == NB'(FRAME_SIZE));
    assign base_sum  = closed_reg ? '0 : sum_reg;
    assign s_mag     = sum_reg[SW-1] ? SW'(-sum_reg) : SW'(sum_reg);
    assign no_data   = !closed_reg || (rp_reg >= count_reg);
    assign spread_d  = (nq_reg >= mul_prod) ? (nq_reg - mul_prod) : '0;

    // numerator N*x - S and its magnitude
    assign nx_s    = signed'({1'b0, mul_prod[NUMW-2:0]});
    assign num_mag = num_reg[NUMW-1] ? NUMW'(-num_reg) : NUMW'(num_reg);

    // saturation of the quotient
    always_comb
    begin
        if (num_reg[NUMW-1])
        begin
            z_val = (div_sat || (div_quot > Z_NEG_LIMIT)) ? Z_MIN : Z_W'(~div_quot + 1'b1);
        end
        else
        begin
            z_val = (div_sat || (div_quot > Z_POS_LIMIT)) ? Z_MAX : Z_W'(div_quot);
        end
    end

    assign cur_idx  = IDX_W'(rp_reg);
    assign cur_last = ((rp_reg + NB'(1)) == count_reg);

    // shared serial multiplier operand select
    always_comb
    begin
        mul_start = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        case (state_reg)
            S_IDLE:
            begin
                mul_start = push_acc && !full;
                mul_a     = PW'(x_mag);
                mul_b     = BW'(x_mag);
            end
            S_CLOSE:
            begin
                mul_start = 1'b1;
                mul_a     = PW'(sq_reg);
                mul_b     = BW'(count_reg);
            end
            S_NQ:
            begin
                mul_start = mul_done;
                mul_a     = PW'(s_mag);
                mul_b     = BW'(s_mag);
            end
            S_RDM:
            begin
                mul_start = 1'b1;
                mul_a     = PW'(rd_mag);
                mul_b     = BW'(count_reg);
            end
            default:
            begin
                mul_start = 1'b0;
            end
        endcase
    end

    assign root_start = (state_reg == S_SS) && mul_done;
    assign div_start  = (state_reg == S_ZCALC) && (root_reg != '0);

    zsn_mul #(.PW(PW), .BW(BW)) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_prod)
    );

    zsn_root #(.DW(DW)) u_root (
        .clk   (clk),
        .rst_n (rst_n),
        .start (root_start),
        .d     (spread_d),
        .done  (root_done),
        .root  (root_val)
    );

    zsn_div #(.NW(MAGW), .RW(RW)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   ({num_mag, FRAC_W'(0)}),
        .den   (root_reg),
        .done  (div_done),
        .sat   (div_sat),
        .quot  (div_quot)
    );

    // sample store, registered read at the read position
    always_ff @(posedge clk)
    begin
        if (push_acc && !full)
        begin
            mem[eff_count[AW-1:0]] <= x_cl;
        end
        rd_reg <= mem[rp_reg[AW-1:0]];
    end

    // sequencer and frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rp_reg        <= '0;
            sum_reg       <= '0;
            sq_reg        <= '0;
            root_reg      <= '0;
            closed_reg    <= 1'b0;
            ovf_reg       <= 1'b0;
            eof_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (push_acc)
                    begin
                        count_reg  <= full ? eff_count : eff_count + NB'(1);
                        sum_reg    <= full ? base_sum : base_sum + SW'(x_cl);
                        sq_reg     <= closed_reg ? '0 : sq_reg;
                        root_reg   <= closed_reg ? '0 : root_reg;
                        rp_reg     <= closed_reg ? '0 : rp_reg;
                        closed_reg <= 1'b0;
                        ovf_reg    <= full || (!closed_reg && ovf_reg);
                        eof_reg    <= request.payload.end_of_frame;
                        if (!full)
                        begin
                            state_reg <= S_SQR;
                        end
                        else if (request.payload.end_of_frame)
                        begin
                            state_reg <= S_CLOSE;
                        end
                    end
                    else if (read_acc)
                    begin
                        state_reg <= no_data ? S_EMIT : S_RDM;
                    end
                end
                S_SQR:
                begin
                    if (mul_done)
                    begin
                        sq_reg    <= sq_reg + QW'(mul_prod);
                        state_reg <= eof_reg ? S_CLOSE : S_IDLE;
                    end
                end
                S_CLOSE:
                begin
                    state_reg <= S_NQ;
                end
                S_NQ:
                begin
                    if (mul_done)
                    begin
                        state_reg <= S_SS;
                    end
                end
                S_SS:
                begin
                    if (mul_done)
                    begin
                        state_reg <= S_ROOT;
                    end
                end
                S_ROOT:
                begin
                    if (root_done)
                    begin
                        root_reg   <= root_val;
                        rp_reg     <= '0;
                        closed_reg <= 1'b1;
                        state_reg  <= S_IDLE;
                    end
                end
                S_RDM:
                begin
                    state_reg <= S_XMUL;
                end
                S_XMUL:
                begin
                    if (mul_done)
                    begin
                        state_reg <= S_ZCALC;
                    end
                end
                S_ZCALC:
                begin
                    if (root_reg == '0)
                    begin
                        rp_reg    <= rp_reg + NB'(1);
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        rp_reg    <= rp_reg + NB'(1);
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT:
                begin
                    if (emit_go)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase

            // output register valid
            if (emit_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (response.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if ((state_reg == S_NQ) && mul_done)
        begin
            nq_reg <= mul_prod;
        end
        if (state_reg == S_RDM)
        begin
            xneg_reg <= rd_reg[SB-1];
        end
        if ((state_reg == S_XMUL) && mul_done)
        begin
            num_reg <= (xneg_reg ? -nx_s : nx_s) - NUMW'(sum_reg);
        end

        // pending result
        if (read_acc && no_data)
        begin
            pend_reg <= '0;
        end
        else if ((state_reg == S_ZCALC) && (root_reg == '0))
        begin
            pend_reg.normalized    <= '0;
            pend_reg.sample_index  <= cur_idx;
            pend_reg.last_of_frame <= cur_last;
            pend_reg.valid_res     <= 1'b1;
            pend_reg.zero_spread   <= 1'b1;
            pend_reg.overflowed    <= ovf_reg;
        end
        else if ((state_reg == S_DIV) && div_done)
        begin
            pend_reg.normalized    <= z_val;
            pend_reg.sample_index  <= cur_idx;
            pend_reg.last_of_frame <= cur_last;
            pend_reg.valid_res     <= 1'b1;
            pend_reg.zero_spread   <= 1'b0;
            pend_reg.overflowed    <= ovf_reg;
        end

        if (emit_go)
        begin
            out_reg <= pend_reg;
        end
    end

`ifndef ASSERT_OFF
    // the frame never holds more samples than the store
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= NB'(FRAME_SIZE))
        else $error("sample count above frame size");

    // a push into a closed frame reopens it
    a_push_reopens: assert property (@(posedge clk) disable iff (!rst_n)
        push_acc && closed_reg |=> !closed_reg)
        else $error("frame still closed after push");

    // zero spread always comes with a zero score
    a_zero_spread: assert property (@(posedge clk) disable iff (!rst_n)
        response.valid && response.payload.zero_spread |-> response.payload.normalized == '0)
        else $error("nonzero score with zero spread");
`endif
endmodule

// File: rtl/zsn_mul.sv
// ----------------------------------------------------------------------------
// zsn_mul: bit-serial shift-add multiplier
// One multiplier bit per cycle, stops early once the remaining bits are zero.
// ----------------------------------------------------------------------------
module zsn_mul #(
    parameter int PW = 52,
    parameter int BW = 27
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [PW-1:0] a,
    input  logic [BW-1:0] b,
    output logic          done,
    output logic [PW-1:0] product
);
    logic          busy_reg;
    logic [PW-1:0] a_reg;
    logic [BW-1:0] b_reg;
    logic [PW-1:0] acc_reg;

    assign done    = busy_reg && (b_reg == '0);
    assign product = acc_reg;

    // busy flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
        end
        else if (done)
        begin
            busy_reg <= 1'b0;
        end
    end

    // shift-add datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
        end
        else if (busy_reg && (b_reg != '0))
        begin
            if (b_reg[0])
            begin
                acc_reg <= acc_reg + a_reg;
            end
            a_reg <= a_reg << 1;
            b_reg <= b_reg >> 1;
        end
    end
endmodule

// File: rtl/zsn_root.sv
// ----------------------------------------------------------------------------
// zsn_root: digit-by-digit integer square root
// Produces one root bit per cycle.
// ----------------------------------------------------------------------------
module zsn_root #(
    parameter int DW = 52
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [DW-1:0]   d,
    output logic            done,
    output logic [DW/2-1:0] root
);
    logic          busy_reg;
    logic [DW-1:0] v_reg;
    logic [DW-1:0] res_reg;
    logic [DW-1:0] bit_reg;
    logic [DW-1:0] trial;

    assign trial = res_reg + bit_reg;
    assign done  = busy_reg && (bit_reg == '0);
    assign root  = res_reg[DW/2-1:0];

    // busy flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
        end
        else if (done)
        begin
            busy_reg <= 1'b0;
        end
    end

    // one root digit per cycle
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            v_reg   <= d;
            res_reg <= '0;
            bit_reg <= DW'(1) << (DW - 2);
        end
        else if (busy_reg && (bit_reg != '0))
        begin
            if (v_reg >= trial)
            begin
                v_reg   <= v_reg - trial;
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end
endmodule

// File: rtl/zsn_div.sv
// ----------------------------------------------------------------------------
// zsn_div: restoring divider
// One quotient bit per cycle; flags quotients that do not fit QUOT_W bits.
// ----------------------------------------------------------------------------
module zsn_div #(
    parameter int NW = 40,
    parameter int RW = 26
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [NW-1:0]             num,
    input  logic [RW-1:0]             den,
    output logic                      done,
    output logic                      sat,
    output logic [zsn_pkg::QUOT_W-1:0] quot
);
    import zsn_pkg::*;

    localparam int CW  = ((NW > RW + QUOT_W) ? NW : RW + QUOT_W) + 1;
    localparam int CNW = $clog2(QUOT_W + 1);

    logic              busy_reg;
    logic [CNW-1:0]    cnt_reg;
    logic [CW-1:0]     rem_reg;
    logic [CW-1:0]     dv_reg;
    logic [QUOT_W-1:0] q_reg;
    logic              sat_reg;

    assign done = busy_reg && (cnt_reg == '0);
    assign sat  = sat_reg;
    assign quot = q_reg;

    // step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNW'(QUOT_W);
        end
        else if (done)
        begin
            busy_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CNW'(1);
        end
    end

    // compare and subtract, divisor walks right
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= CW'(num);
            dv_reg  <= CW'(den) << (QUOT_W - 1);
            q_reg   <= '0;
            sat_reg <= CW'(num) >= (CW'(den) << QUOT_W);
        end
        else if (busy_reg && (cnt_reg != '0))
        begin
            if (rem_reg >= dv_reg)
            begin
                rem_reg <= rem_reg - dv_reg;
                q_reg   <= {q_reg[QUOT_W-2:0], 1'b1};
            end
            else
            begin
                q_reg <= {q_reg[QUOT_W-2:0], 1'b0};
            end
            dv_reg <= dv_reg >> 1;
        end
    end
endmodule

// File: bench/tb_frame_zscore_normalizer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_frame_zscore_normalizer_top: self-checking bench of the z-score normalizer
// Random frames of pushes are followed by reads. Every read is predicted by a
// behavioral model kept inside the bench and compared field by field with the
// response channel, under random idling on both sides.
// ----------------------------------------------------------------------------
module tb_frame_zscore_normalizer_top;
    import zsn_pkg::*;

    localparam int FRAME_SIZE = 1024;
    localparam int WATCHDOG   = 20000;

    logic clk;
    logic rst_n;

    zsn_stream_if #(.payload_t(request_t)) request ();
    zsn_stream_if #(.payload_t(result_t))  response ();

    frame_zscore_normalizer_top #(.FRAME_SIZE(FRAME_SIZE), .SAMPLE_BITS(SAMPLE_W)) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (request.sink),
        .response (response.source)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // predictor state
    logic signed [SAMPLE_W-1:0] frame_mem [FRAME_SIZE];
    int unsigned    frame_len;
    int unsigned    read_pos;
    longint         frame_sum;
    longint unsigned square_sum;
    longint unsigned spread;
    bit             closed;
    bit             dropped;

    request_t pending_pushes [$];
    result_t  expected_results [$];
    int       error_count;
    int       results_seen;
    int       frames_closed;
    int       overflow_frames;
    int       zero_spread_seen;
    int       saturated_seen;
    int       idle_cycles;
    bit       stim_done;
    int       long_hold;

    function automatic longint unsigned isqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    // update the model for one accepted transfer
    task automatic predict_request(request_t t);
        longint x;
        longint num;
        longint z;
        longint unsigned q;
        longint unsigned nq;
        longint unsigned ss;
        longint unsigned smag;
        result_t r;
        r = '0;
        if (t.command == CMD_PUSH)
        begin
            x = t.sample;
            if (closed)
            begin
                frame_len = 0; read_pos = 0; frame_sum = 0; square_sum = 0;
                spread = 0; closed = 0; dropped = 0;
            end
            if (frame_len < FRAME_SIZE)
            begin
                frame_mem[frame_len] = t.sample;
                frame_len++;
                frame_sum += x;
                square_sum += longint'(x * x);
            end
            else
                dropped = 1;
            if (t.end_of_frame)
            begin
                smag = frame_sum < 0 ? -frame_sum : frame_sum;
                nq = longint'(frame_len) * square_sum;
                ss = smag * smag;
                spread = isqrt(nq >= ss ? nq - ss : 0);
                read_pos = 0;
                closed = 1;
                frames_closed++;
                if (dropped)
                    overflow_frames++;
            end
            return;
        end
        if (closed && read_pos < frame_len)
        begin
            x = frame_mem[read_pos];
            num = longint'(frame_len) * x - frame_sum;
            z = 0;
            if (spread != 0)
            begin
                q = (num < 0 ? -num : num) * 4096 / spread;
                if (num < 0)
                    z = q > 524288 ? -524288 : -longint'(q);
                else
                    z = q > 524287 ? 524287 : longint'(q);
                if (z == 524287 || z == -524288)
                    saturated_seen++;
            end
            else
                zero_spread_seen++;
            r.normalized    = z[Z_W-1:0];
            r.sample_index  = read_pos[IDX_W-1:0];
            r.last_of_frame = (read_pos + 1 == frame_len);
            r.valid_res     = 1'b1;
            r.zero_spread   = (spread == 0);
            r.overflowed    = dropped;
            read_pos++;
        end
        expected_results.push_back(r);
    endtask

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch at result %0d: %s got %0d expected %0d",
                 results_seen, what, got, want);
        error_count++;
    endtask

    // stimulus helpers
    task automatic add_push(logic signed [SAMPLE_W-1:0] s, bit eof);
        request_t t;
        t.command = CMD_PUSH;
        t.sample = s;
        t.end_of_frame = eof;
        pending_pushes.push_back(t);
    endtask

    task automatic add_read(bit eof_noise);
        request_t t;
        t.command = CMD_READ;
        t.sample = SAMPLE_W'($urandom);
        t.end_of_frame = eof_noise;
        pending_pushes.push_back(t);
    endtask

    function automatic logic [SAMPLE_W-1:0] random_sample();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return SAMPLE_W'($urandom_range(0, 15)) - 16'd8;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // driver: one transfer at a time with random gaps
    int send_gap;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            request.valid   <= 1'b0;
            request.payload <= '0;
            send_gap        <= 0;
        end
        else
        begin
            if (request.valid && request.ready)
                predict_request(request.payload);
            if (request.valid && !request.ready)
                ;
            else if (send_gap > 0)
            begin
                request.valid <= 1'b0;
                send_gap <= send_gap - 1;
            end
            else if (pending_pushes.size() > 0)
            begin
                request.valid   <= 1'b1;
                request.payload <= pending_pushes.pop_front();
                send_gap        <= $urandom_range(0, 3);
            end
            else
            begin
                request.valid <= 1'b0;
                stim_done <= (request.valid && request.ready) || !request.valid;
            end
        end
    end

    // monitor: random stalls, one long hold-off, and the checker
    int recv_gap;
    int recv_draw;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            response.ready <= 1'b0;
            recv_gap       <= 0;
        end
        else
        begin
            if (response.valid && response.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    report_mismatch("unexpected result", 1, 0);
                end
                else
                begin
                    result_t e;
                    result_t g;
                    e = expected_results.pop_front();
                    g = response.payload;
                    if (g.normalized !== e.normalized)
                        report_mismatch("normalized", g.normalized, e.normalized);
                    if (g.sample_index !== e.sample_index)
                        report_mismatch("sample_index", g.sample_index, e.sample_index);
                    if (g.last_of_frame !== e.last_of_frame)
                        report_mismatch("last_of_frame", g.last_of_frame, e.last_of_frame);
                    if (g.valid_res !== e.valid_res)
                        report_mismatch("valid_res", g.valid_res, e.valid_res);
                    if (g.zero_spread !== e.zero_spread)
                        report_mismatch("zero_spread", g.zero_spread, e.zero_spread);
                    if (g.overflowed !== e.overflowed)
                        report_mismatch("overflowed", g.overflowed, e.overflowed);
                end
                results_seen++;
                recv_draw = $urandom_range(0, 3);
                recv_gap <= (recv_draw > 0) ? recv_draw - 1 : 0;
                response.ready <= (recv_draw == 0);
            end
            else if (long_hold > 0)
            begin
                long_hold <= long_hold - 1;
                response.ready <= 1'b0;
            end
            else if (recv_gap > 0)
            begin
                recv_gap <= recv_gap - 1;
                response.ready <= 1'b0;
            end
            else
                response.ready <= 1'b1;
        end
    end

    // watchdog on cycles with no transfer
    always @(posedge clk)
    begin
        if (!rst_n || (request.valid && request.ready) || (response.valid && response.ready)
            || long_hold > 0)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        int n;
        int kind;
        frame_len = 0; read_pos = 0; frame_sum = 0; square_sum = 0; spread = 0;
        closed = 0; dropped = 0; error_count = 0; results_seen = 0;
        frames_closed = 0; overflow_frames = 0; zero_spread_seen = 0;
        saturated_seen = 0; idle_cycles = 0; stim_done = 0; long_hold = 0;
        request.valid = 1'b0;
        request.payload = '0;
        response.ready = 1'b0;

        // directed: read before any frame, extremes, constant frame, single sample
        add_read(1'b1);
        add_push(16'sh8000, 0);
        add_push(16'sh7fff, 0);
        add_push(16'sh0000, 1);
        for (int i = 0; i < 4; i++)
            add_read(i[0]);
        add_push(16'sh1234, 0);
        add_push(16'sh1234, 1);
        add_read(0);
        add_read(0);
        add_read(0);
        add_push(16'sh8000, 0);
        add_push(16'sh7fff, 1);
        add_push(16'sh0005, 1);
        add_read(0);
        add_read(0);
        add_read(0);

        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // a mid-size frame read past its end, with the receiver held off
        for (int i = 0; i < 48; i++)
            add_push(random_sample(), i == 47);
        for (int i = 0; i < 50; i++)
            add_read(0);
        long_hold = 600;

        // random frames, mostly small, read out partly, fully or past the end
        n = pending_pushes.size();
        while (n < 750)
        begin
            kind = $urandom_range(1, 12);
            for (int i = 0; i < kind; i++)
                add_push(random_sample(), (i == kind - 1) && ($urandom_range(0, 9) != 0));
            n += kind;
            kind = $urandom_range(0, kind + 2);
            for (int i = 0; i < kind; i++)
                add_read($urandom_range(0, 1));
            n += kind;
        end

        fork
            begin
                wait (stim_done && pending_pushes.size() == 0 && expected_results.size() == 0);
                repeat (200) @(posedge clk);
            end
            wait (idle_cycles >= WATCHDOG);
        join_any
        if (idle_cycles >= WATCHDOG)
        begin
            $display("watchdog: no transfer for %0d cycles", WATCHDOG);
            $display("tb_frame_zscore_normalizer_top: errors");
        end
        else
        begin
            $display("covered %0d results over %0d closed frames, %0d with dropped pushes",
                     results_seen, frames_closed, overflow_frames);
            $display("zero-spread reads %0d, saturated reads %0d",
                     zero_spread_seen, saturated_seen);
            if (error_count == 0 && expected_results.size() == 0)
                $display("tb_frame_zscore_normalizer_top: clean");
            else
                $display("tb_frame_zscore_normalizer_top: errors");
        end
        $finish;
    end
endmodule

// File: sim.f
rtl/zsn_pkg.sv
rtl/zsn_stream_if.sv
rtl/zsn_mul.sv
rtl/zsn_root.sv
rtl/zsn_div.sv
rtl/frame_zscore_normalizer_top.sv
bench/tb_frame_zscore_normalizer_top.sv
